FILE: sv/tmc_pkg.sv
// ---------------------------------------------------------------------------
// tmc_pkg: shared types and constants for temperature mass compensation
// Widths, status and register codes, and lane/result records.
// ---------------------------------------------------------------------------
package tmc_pkg;

    localparam int SENSOR_COUNT = 4;
    localparam int LANE_STAGES  = 4;
    localparam int MERGE_STAGES = 6;
    localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

    localparam int TEMP_W  = 16;
    localparam int COEF_W  = 16;
    localparam int DIFF_W  = 15;  // |temp - ref| <= 13120 for in-range values
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int LIN_W   = COEF_W + DIFF_W;
    localparam int QUAD_W  = COEF_W + SQ_W;
    localparam int TERM_W  = 47;
    localparam int ACC_W   = 49;
    localparam int MASS_W  = 40;
    localparam int OFF_W   = ACC_W - 20;
    localparam int SPAN_W  = ACC_W - 14;
    localparam int EFF_W   = 34;
    localparam int HALF_W  = MASS_W / 2;
    localparam int PART_W  = HALF_W + EFF_W;
    localparam int MAG_W   = 45;
    localparam int COR_W   = 47;
    localparam int TOT_W   = 48;
    localparam int VAL_W   = 40;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd3520;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd9600;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_NOT_CONFIGURED = 3'd1,
        ST_INVALID_MODEL  = 3'd2,
        ST_SENSOR_FAULT   = 3'd3,
        ST_VERIFY_FAILED  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL_READY = 3'd0,
        CFG_SENSOR_EN   = 3'd1,
        CFG_REF_TEMPS   = 3'd2,
        CFG_OFF_LIN     = 3'd3,
        CFG_OFF_QUAD    = 3'd4,
        CFG_SPAN_LIN    = 3'd5,
        CFG_SPAN_QUAD   = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic en;
        logic ref_bad;
        logic missing;
        logic oor;
    } t_lane_flags;

    typedef struct packed {
        t_lane_flags              flags;
        logic signed [TERM_W-1:0] off;
        logic signed [TERM_W-1:0] span;
    } t_lane_res;

    typedef struct packed {
        logic signed [VAL_W-1:0] total;
        logic signed [VAL_W-1:0] span;
        logic signed [VAL_W-1:0] off;
        logic signed [VAL_W-1:0] cor;
        t_status                 status;
    } t_result;

endpackage

FILE: sv/tmc_lane.sv
// ---------------------------------------------------------------------------
// tmc_lane: per-sensor correction terms
// Four-stage pipeline: difference, products, squared products, term sums.
// ---------------------------------------------------------------------------
module tmc_lane
    import tmc_pkg::*;
(
    input  logic                     i_clk,
    input  logic [LANE_STAGES-1:0]   i_ld,
    input  logic                     i_en,
    input  logic                     i_rd_valid,
    input  logic signed [TEMP_W-1:0] i_temp,
    input  logic signed [TEMP_W-1:0] i_ref,
    input  logic signed [COEF_W-1:0] i_a,
    input  logic signed [COEF_W-1:0] i_b,
    input  logic signed [COEF_W-1:0] i_c,
    input  logic signed [COEF_W-1:0] i_e,
    output t_lane_res                o_lane
);

    logic signed [TEMP_W:0]   n_diff;
    t_lane_flags              n_flags;
    t_lane_flags              r_flags [LANE_STAGES];
    logic signed [DIFF_W-1:0] r_d;
    logic signed [SQ_W-1:0]   r_d2;
    logic signed [LIN_W-1:0]  r_ad;
    logic signed [LIN_W-1:0]  r_cd;
    logic signed [LIN_W-1:0]  r_ad2;
    logic signed [LIN_W-1:0]  r_cd2;
    logic signed [QUAD_W-1:0] r_bd2;
    logic signed [QUAD_W-1:0] r_ed2;
    logic signed [TERM_W-1:0] n_off;
    logic signed [TERM_W-1:0] n_span;
    logic signed [TERM_W-1:0] r_off;
    logic signed [TERM_W-1:0] r_span;

    always_comb begin
        n_diff          = (TEMP_W+1)'(i_temp) - (TEMP_W+1)'(i_ref);
        n_flags.en      = i_en;
        n_flags.ref_bad = (i_ref < TEMP_MIN) || (i_ref > TEMP_MAX);
        n_flags.missing = !i_rd_valid;
        n_flags.oor     = (i_temp < TEMP_MIN) || (i_temp > TEMP_MAX);
    end

    // Drop the term of a disabled sensor so the merge can sum all lanes.
    always_comb begin
        if (r_flags[2].en) begin
            n_off  = (TERM_W'(r_ad2) <<< 14) + TERM_W'(r_bd2);
            n_span = (TERM_W'(r_cd2) <<< 14) + TERM_W'(r_ed2);
        end else begin
            n_off  = '0;
            n_span = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_d        <= n_diff[DIFF_W-1:0];
            r_flags[0] <= n_flags;
        end
        if (i_ld[1]) begin
            r_d2       <= SQ_W'(r_d) * SQ_W'(r_d);
            r_ad       <= LIN_W'(i_a) * LIN_W'(r_d);
            r_cd       <= LIN_W'(i_c) * LIN_W'(r_d);
            r_flags[1] <= r_flags[0];
        end
        if (i_ld[2]) begin
            r_bd2      <= QUAD_W'(i_b) * QUAD_W'(r_d2);
            r_ed2      <= QUAD_W'(i_e) * QUAD_W'(r_d2);
            r_ad2      <= r_ad;
            r_cd2      <= r_cd;
            r_flags[2] <= r_flags[1];
        end
        if (i_ld[3]) begin
            r_off      <= n_off;
            r_span     <= n_span;
            r_flags[3] <= r_flags[2];
        end
    end

    assign o_lane.flags = r_flags[3];
    assign o_lane.off   = r_off;
    assign o_lane.span  = r_span;

endmodule

FILE: sv/tmc_merge.sv
// ---------------------------------------------------------------------------
// tmc_merge: lane merge, rounding and mass scaling
// Sums lane terms, decides status, scales the mass and checks range.
// ---------------------------------------------------------------------------
module tmc_merge
    import tmc_pkg::*;
(
    input  logic                          i_clk,
    input  logic [MERGE_STAGES-1:0]       i_ld,
    input  logic                          i_model_ready,
    input  t_lane_res [SENSOR_COUNT-1:0]  i_lane,
    input  logic signed [MASS_W-1:0]      i_mass,
    output t_result                       o_res
);

    localparam logic signed [ACC_W-1:0] HALF_OFF  = ACC_W'(1) <<< 19;
    localparam logic signed [ACC_W-1:0] HALF_SPAN = ACC_W'(1) <<< 13;
    localparam logic signed [SPAN_W:0]  ONE_SPAN  = (SPAN_W+1)'(1) <<< 30;
    localparam logic [PART_W+HALF_W:0]  HALF_MAG  = (PART_W+HALF_W+1)'(1) << 29;
    localparam logic signed [TOT_W-1:0] LIM40     = TOT_W'(1) <<< 39;

    // stage 1: status and lane sums
    t_status                  n_stat1;
    logic signed [ACC_W-1:0]  n_off_acc;
    logic signed [ACC_W-1:0]  n_span_acc;
    t_status                  r_stat1;
    logic signed [ACC_W-1:0]  r_off_acc;
    logic signed [ACC_W-1:0]  r_span_acc;
    logic signed [MASS_W-1:0] r_mass1;

    // stage 2: rounding, effective span, mass magnitude
    logic signed [ACC_W-1:0]  n_off_rnd;
    logic signed [ACC_W-1:0]  n_span_rnd;
    logic signed [SPAN_W:0]   n_eff;
    logic [MASS_W-1:0]        n_um;
    t_status                  r_stat2;
    logic signed [OFF_W-1:0]  r_off2;
    logic signed [SPAN_W-1:0] r_span2;
    logic [EFF_W-1:0]         r_eff2;
    logic [MASS_W-1:0]        r_um2;
    logic                     r_neg2;
    logic signed [MASS_W-1:0] r_mass2;

    // stage 3: partial products
    logic [PART_W-1:0]        r_pa;
    logic [PART_W-1:0]        r_pb;
    t_status                  r_stat3;
    logic signed [OFF_W-1:0]  r_off3;
    logic signed [SPAN_W-1:0] r_span3;
    logic                     r_neg3;
    logic signed [MASS_W-1:0] r_mass3;

    // stage 4: rounded magnitude
    logic [PART_W+HALF_W:0]   n_psum;
    logic [MAG_W-1:0]         r_mag;
    t_status                  r_stat4;
    logic signed [OFF_W-1:0]  r_off4;
    logic signed [SPAN_W-1:0] r_span4;
    logic                     r_neg4;
    logic signed [MASS_W-1:0] r_mass4;

    // stage 5: corrected mass
    logic signed [COR_W-1:0]  n_mag_s;
    logic signed [COR_W-1:0]  r_cor;
    t_status                  r_stat5;
    logic signed [OFF_W-1:0]  r_off5;
    logic signed [SPAN_W-1:0] r_span5;
    logic signed [MASS_W-1:0] r_mass5;

    // stage 6: range check and output
    logic signed [TOT_W-1:0]  n_total;
    logic signed [TOT_W-1:0]  n_cor_w;
    logic                     n_ovf;
    t_result                  n_res;
    t_result                  r_res;

    always_comb begin
        logic found;
        logic any_en;
        logic ref_bad;
        found      = 1'b0;
        any_en     = 1'b0;
        ref_bad    = 1'b0;
        n_stat1    = ST_OK;
        n_off_acc  = '0;
        n_span_acc = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            n_off_acc  = n_off_acc + ACC_W'(i_lane[i].off);
            n_span_acc = n_span_acc + ACC_W'(i_lane[i].span);
            if (i_lane[i].flags.en) begin
                any_en = 1'b1;
                if (i_lane[i].flags.ref_bad) begin
                    ref_bad = 1'b1;
                end
            end
        end
        // First enabled sensor with a missing or out-of-range reading decides.
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (!found && i_lane[i].flags.en) begin
                if (i_lane[i].flags.missing) begin
                    found   = 1'b1;
                    n_stat1 = ST_NOT_CONFIGURED;
                end else if (i_lane[i].flags.oor) begin
                    found   = 1'b1;
                    n_stat1 = ST_SENSOR_FAULT;
                end
            end
        end
        priority if (!i_model_ready) begin
            n_stat1 = ST_NOT_CONFIGURED;
        end else if (ref_bad) begin
            n_stat1 = ST_INVALID_MODEL;
        end else if (!any_en) begin
            n_stat1 = ST_NOT_CONFIGURED;
        end else begin
            n_stat1 = n_stat1;
        end
    end

    // Round half away from zero: bias by half, less one for negatives.
    always_comb begin
        n_off_rnd  = (r_off_acc + HALF_OFF
                   - ACC_W'($signed({1'b0, r_off_acc[ACC_W-1]}))) >>> 20;
        n_span_rnd = (r_span_acc + HALF_SPAN
                   - ACC_W'($signed({1'b0, r_span_acc[ACC_W-1]}))) >>> 14;
        n_eff      = (SPAN_W+1)'(n_span_rnd) + ONE_SPAN;
        n_um       = r_mass1[MASS_W-1] ? MASS_W'(-r_mass1) : MASS_W'(r_mass1);
    end

    always_comb begin
        n_psum  = ((PART_W+HALF_W+1)'(r_pa) << HALF_W) + (PART_W+HALF_W+1)'(r_pb)
                + HALF_MAG;
        n_mag_s = $signed({{(COR_W-MAG_W){1'b0}}, r_mag});
    end

    always_comb begin
        n_cor_w = TOT_W'(r_cor);
        n_total = n_cor_w - TOT_W'(r_mass5);
        n_ovf   = (n_cor_w < -LIM40) || (n_cor_w >= LIM40)
               || (n_total < -LIM40) || (n_total >= LIM40);
        if (r_stat5 == ST_OK && n_ovf) begin
            n_res.status = ST_VERIFY_FAILED;
        end else begin
            n_res.status = r_stat5;
        end
        if (n_res.status == ST_OK) begin
            n_res.cor   = r_cor[VAL_W-1:0];
            n_res.off   = VAL_W'(r_off5);
            n_res.span  = VAL_W'(r_span5);
            n_res.total = n_total[VAL_W-1:0];
        end else begin
            n_res.cor   = '0;
            n_res.off   = '0;
            n_res.span  = '0;
            n_res.total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_stat1    <= n_stat1;
            r_off_acc  <= n_off_acc;
            r_span_acc <= n_span_acc;
            r_mass1    <= i_mass;
        end
        if (i_ld[1]) begin
            if (r_stat1 == ST_OK && (n_eff[SPAN_W] || n_eff == '0)) begin
                r_stat2 <= ST_VERIFY_FAILED;
            end else begin
                r_stat2 <= r_stat1;
            end
            r_off2  <= n_off_rnd[OFF_W-1:0];
            r_span2 <= n_span_rnd[SPAN_W-1:0];
            r_eff2  <= n_eff[EFF_W-1:0];
            r_um2   <= n_um;
            r_neg2  <= r_mass1[MASS_W-1];
            r_mass2 <= r_mass1;
        end
        if (i_ld[2]) begin
            r_pa    <= PART_W'(r_um2[MASS_W-1:HALF_W]) * PART_W'(r_eff2);
            r_pb    <= PART_W'(r_um2[HALF_W-1:0]) * PART_W'(r_eff2);
            r_stat3 <= r_stat2;
            r_off3  <= r_off2;
            r_span3 <= r_span2;
            r_neg3  <= r_neg2;
            r_mass3 <= r_mass2;
        end
        if (i_ld[3]) begin
            r_mag   <= n_psum[MAG_W+29:30];
            r_stat4 <= r_stat3;
            r_off4  <= r_off3;
            r_span4 <= r_span3;
            r_neg4  <= r_neg3;
            r_mass4 <= r_mass3;
        end
        if (i_ld[4]) begin
            r_cor   <= (r_neg4 ? -n_mag_s : n_mag_s) + COR_W'(r_off4);
            r_stat5 <= r_stat4;
            r_off5  <= r_off4;
            r_span5 <= r_span4;
            r_mass5 <= r_mass4;
        end
        if (i_ld[5]) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: sv/temperature_mass_compensation.sv
// ---------------------------------------------------------------------------
// temperature_mass_compensation: quadratic temperature compensation of mass
// Top level: configuration registers, sensor lanes, merge and handshake.
// ---------------------------------------------------------------------------
// The block accepts one sample per clock while the output side keeps up,
// and it returns one result per sample, in order, on the result stream. The
// pace is set by the pipeline: four stages in each of the four sensor lanes
// (difference, linear and square products, quadratic products, term sums)
// and six in the merge (lane sum and status, rounding, two 20x34 partial
// products of the mass scaling, magnitude assembly, offset add and range
// check). Each stage holds its own valid bit, so a stalled output only holds
// the stages that are full; empty stages behind it keep taking samples.
// Write configuration only while the pipeline is empty; the lanes read the
// registers live. A result's value fields are zero unless status is OK.
module temperature_mass_compensation
    import tmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // input sample stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata, from bit 0: temp_0[15:0], temp_1[31:16], temp_2[47:32],
    // temp_3[63:48], reading_valid_mask[67:64], mass_in[107:68], zero pad
    input  logic [111:0]         s_tdata,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata, from bit 0: status[2:0], corrected_mass[42:3],
    // offset_correction[82:43], span_correction[122:83],
    // total_correction[162:123], zero pad
    output logic [167:0]         m_tdata
);

    localparam int MASK_LSB = SENSOR_COUNT * TEMP_W;
    localparam int MASS_LSB = 4 * TEMP_W + 4;

    // configuration registers
    logic                    r_model_ready;
    logic [3:0]              r_sensor_en;
    logic [CFG_W-1:0]        r_ref;
    logic [CFG_W-1:0]        r_off_lin;
    logic [CFG_W-1:0]        r_off_quad;
    logic [CFG_W-1:0]        r_span_lin;
    logic [CFG_W-1:0]        r_span_quad;

    // pipeline control
    logic [PIPE_STAGES-1:0]  r_vld;
    logic [PIPE_STAGES-1:0]  ld;

    // mass travels alongside the lane stages
    logic signed [MASS_W-1:0] r_mass [LANE_STAGES];

    t_lane_res [SENSOR_COUNT-1:0] lane_res;
    t_result                      res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_ready <= 1'b0;
            r_sensor_en   <= '0;
            r_ref         <= '0;
            r_off_lin     <= '0;
            r_off_quad    <= '0;
            r_span_lin    <= '0;
            r_span_quad   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MODEL_READY: r_model_ready <= i_cfg_wdata[0];
                CFG_SENSOR_EN:   r_sensor_en   <= i_cfg_wdata[3:0];
                CFG_REF_TEMPS:   r_ref         <= i_cfg_wdata;
                CFG_OFF_LIN:     r_off_lin     <= i_cfg_wdata;
                CFG_OFF_QUAD:    r_off_quad    <= i_cfg_wdata;
                CFG_SPAN_LIN:    r_span_lin    <= i_cfg_wdata;
                CFG_SPAN_QUAD:   r_span_quad   <= i_cfg_wdata;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it loads.
    always_comb begin
        ld[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || m_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= s_tvalid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_mass[0] <= s_tdata[MASS_LSB +: MASS_W];
        end
        for (int k = 1; k < LANE_STAGES; k++) begin
            if (ld[k]) begin
                r_mass[k] <= r_mass[k-1];
            end
        end
    end

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        tmc_lane u_lane (
            .i_clk      (i_clk),
            .i_ld       (ld[LANE_STAGES-1:0]),
            .i_en       (r_sensor_en[g]),
            .i_rd_valid (s_tdata[MASK_LSB + g]),
            .i_temp     (s_tdata[g*TEMP_W +: TEMP_W]),
            .i_ref      (r_ref[g*COEF_W +: COEF_W]),
            .i_a        (r_off_lin[g*COEF_W +: COEF_W]),
            .i_b        (r_off_quad[g*COEF_W +: COEF_W]),
            .i_c        (r_span_lin[g*COEF_W +: COEF_W]),
            .i_e        (r_span_quad[g*COEF_W +: COEF_W]),
            .o_lane     (lane_res[g])
        );
    end

    tmc_merge u_merge (
        .i_clk         (i_clk),
        .i_ld          (ld[PIPE_STAGES-1:LANE_STAGES]),
        .i_model_ready (r_model_ready),
        .i_lane        (lane_res),
        .i_mass        (r_mass[LANE_STAGES-1]),
        .o_res         (res)
    );

    assign s_tready = ld[0];
    assign m_tvalid = r_vld[PIPE_STAGES-1];
    assign m_tdata  = {5'b0, res.total, res.span, res.off, res.cor, 3'(res.status)};

endmodule
